// File: rtl/core/cfp_pkg.sv
// Package for the CO2 sensor frame parser: codes, constants and the structs
// passed between the front end, the event queue and the back end.
// No dependencies.
package cfp_pkg;

    localparam int FRAME_LENGTH = 9;
    localparam int POS_W        = 4;
    localparam int QUEUE_DEPTH  = 4;
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 16;

    localparam logic [7:0]  HEADER_BYTE        = 8'hFF;
    localparam logic [7:0]  READ_COMMAND       = 8'h86;
    localparam logic [7:0]  TEMP_OFFSET        = 8'd40;
    localparam logic [15:0] WARMUP_SECONDS_RST = 16'd180;
    localparam logic [15:0] MIN_VALID_PPM_RST  = 16'd250;
    localparam logic [15:0] UPTIME_MAX         = 16'hFFFF;

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        STATUS_OK           = 2'd0,
        STATUS_BAD_CHECKSUM = 2'd1,
        STATUS_NOT_READING  = 2'd2
    } status_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_WARMUP_SECONDS = 1'b0,
        CFG_MIN_VALID_PPM  = 1'b1
    } cfg_index_t;

    // One queued event: a tick, or a completed frame already classified
    typedef struct packed {
        logic        is_tick;
        logic        sum_ok;
        logic        cmd_ok;
        logic [15:0] ppm;
        logic [7:0]  temp_raw;
        logic [7:0]  extra;
    } event_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] ppm;
        logic [7:0]  temperature;
        logic [7:0]  extra_byte;
        logic        warming_up;
        logic        ppm_valid;
    } result_t;

endpackage

// File: rtl/core/cfp_front.sv
// Front end: hunts for the frame header, gathers frame bytes, checks the
// checksum and command, and queues one event per tick or completed frame.
// Depends on cfp_pkg.
module cfp_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic             opcode,
    input  logic [7:0]       rx_byte,
    output logic             enq_valid,
    output cfp_pkg::event_t  enq_event
);

    logic [cfp_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [7:0]  ppm_hi_reg, ppm_hi_next;
    logic [7:0]  ppm_lo_reg, ppm_lo_next;
    logic [7:0]  temp_reg, temp_next;
    logic [7:0]  extra_reg, extra_next;
    logic [7:0]  sum_plus;

    assign sum_plus = sum_reg + rx_byte;

    always_comb
    begin
        pos_next    = pos_reg;
        sum_next    = sum_reg;
        cmd_next    = cmd_reg;
        ppm_hi_next = ppm_hi_reg;
        ppm_lo_next = ppm_lo_reg;
        temp_next   = temp_reg;
        extra_next  = extra_reg;
        enq_valid   = 1'b0;
        enq_event   = '0;
        if (accept)
        begin
            if (cfp_pkg::opcode_t'(opcode) == cfp_pkg::OP_TICK)
            begin
                enq_valid         = 1'b1;
                enq_event.is_tick = 1'b1;
            end
            else if (pos_reg == '0)
            begin
                if (rx_byte == cfp_pkg::HEADER_BYTE)
                begin
                    pos_next = cfp_pkg::POS_W'(1);
                    sum_next = '0;
                end
            end
            else
            begin
                case (pos_reg)
                    cfp_pkg::POS_W'(1): cmd_next    = rx_byte;
                    cfp_pkg::POS_W'(2): ppm_hi_next = rx_byte;
                    cfp_pkg::POS_W'(3): ppm_lo_next = rx_byte;
                    cfp_pkg::POS_W'(4): temp_next   = rx_byte;
                    cfp_pkg::POS_W'(6): extra_next  = rx_byte;
                    default:            ;
                endcase
                if (pos_reg < cfp_pkg::POS_W'(cfp_pkg::FRAME_LENGTH - 1))
                begin
                    sum_next = sum_plus;
                    pos_next = pos_reg + cfp_pkg::POS_W'(1);
                end
                else
                begin
                    // checksum byte: sum of bytes 1..7 plus checksum wraps to zero
                    pos_next           = '0;
                    enq_valid          = 1'b1;
                    enq_event.sum_ok   = (sum_plus == 8'd0);
                    enq_event.cmd_ok   = (cmd_reg == cfp_pkg::READ_COMMAND);
                    enq_event.ppm      = {ppm_hi_reg, ppm_lo_reg};
                    enq_event.temp_raw = temp_reg;
                    enq_event.extra    = extra_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            sum_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        ppm_hi_reg <= ppm_hi_next;
        ppm_lo_reg <= ppm_lo_next;
        temp_reg   <= temp_next;
        extra_reg  <= extra_next;
    end

`ifndef SYNTHESIS
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg < cfp_pkg::POS_W'(cfp_pkg::FRAME_LENGTH))
        else $error("frame position out of range");
    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        (enq_valid && !enq_event.is_tick) |=> (pos_reg == '0))
        else $error("frame event without return to hunting");
`endif

endmodule

// File: rtl/core/cfp_queue.sv
// Short event queue between the front end and the back end.
// Depends on cfp_pkg.
module cfp_queue #(
    parameter int DEPTH = cfp_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             enq_valid,
    input  cfp_pkg::event_t  enq_event,
    output logic             full,
    output logic             deq_valid,
    output cfp_pkg::event_t  deq_event,
    input  logic             deq_ready
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cfp_pkg::event_t entries_reg [DEPTH];
    logic [IDX_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [IDX_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic do_enq, do_deq;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign deq_valid = (count_reg != '0);
    assign deq_event = entries_reg[rd_ptr_reg];
    assign do_enq    = enq_valid && !full;
    assign do_deq    = deq_ready && deq_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_enq)
            wr_ptr_next = (wr_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + IDX_W'(1);
        if (do_deq)
            rd_ptr_next = (rd_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + IDX_W'(1);
        if (do_enq && !do_deq)
            count_next = count_reg + CNT_W'(1);
        else if (!do_enq && do_deq)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_enq)
            entries_reg[wr_ptr_reg] <= enq_event;
    end

`ifndef SYNTHESIS
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count exceeds depth");
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        !(enq_valid && full))
        else $error("event offered to a full queue");
`endif

endmodule

// File: rtl/core/cfp_back.sv
// Back end: keeps uptime, warm-up state and configuration, turns queued
// events into results and holds the result register. Depends on cfp_pkg.
module cfp_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [cfp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [cfp_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               deq_valid,
    input  cfp_pkg::event_t                    deq_event,
    output logic                               deq_ready,
    output logic                               out_valid,
    input  logic                               out_pop,
    output cfp_pkg::result_t                   result
);

    logic [15:0] warmup_seconds_reg;
    logic [15:0] min_valid_ppm_reg;
    logic [15:0] uptime_reg, uptime_next;
    logic        warmup_reg, warmup_next;
    logic        out_valid_reg, out_valid_next;
    cfp_pkg::result_t result_reg, result_next;
    logic        pop_ok, advance;

    assign pop_ok    = out_pop && out_valid_reg;
    assign advance   = deq_valid && (deq_event.is_tick || !out_valid_reg || pop_ok);
    assign deq_ready = advance;
    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    always_comb
    begin
        uptime_next    = uptime_reg;
        warmup_next    = warmup_reg;
        out_valid_next = out_valid_reg && !pop_ok;
        result_next    = result_reg;
        if (advance)
        begin
            if (deq_event.is_tick)
            begin
                if (uptime_reg != cfp_pkg::UPTIME_MAX)
                    uptime_next = uptime_reg + 16'd1;
            end
            else
            begin
                out_valid_next = 1'b1;
                result_next    = '0;
                if (!deq_event.sum_ok)
                begin
                    result_next.status     = cfp_pkg::STATUS_BAD_CHECKSUM;
                    result_next.warming_up = warmup_reg;
                end
                else if (!deq_event.cmd_ok)
                begin
                    result_next.status     = cfp_pkg::STATUS_NOT_READING;
                    result_next.warming_up = warmup_reg;
                end
                else
                begin
                    if (uptime_reg > warmup_seconds_reg || deq_event.extra != 8'd0)
                        warmup_next = 1'b0;
                    result_next.status      = cfp_pkg::STATUS_OK;
                    result_next.ppm         = deq_event.ppm;
                    result_next.temperature = deq_event.temp_raw - cfp_pkg::TEMP_OFFSET;
                    result_next.extra_byte  = deq_event.extra;
                    result_next.warming_up  = warmup_next;
                    result_next.ppm_valid   = !warmup_next
                                              && (deq_event.ppm >= min_valid_ppm_reg);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warmup_seconds_reg <= cfp_pkg::WARMUP_SECONDS_RST;
            min_valid_ppm_reg  <= cfp_pkg::MIN_VALID_PPM_RST;
            uptime_reg         <= '0;
            warmup_reg         <= 1'b1;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfp_pkg::cfg_index_t'(cfg_index))
                    cfp_pkg::CFG_WARMUP_SECONDS: warmup_seconds_reg <= cfg_data;
                    cfp_pkg::CFG_MIN_VALID_PPM:  min_valid_ppm_reg  <= cfg_data;
                endcase
            end
            uptime_reg    <= uptime_next;
            warmup_reg    <= warmup_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

`ifndef SYNTHESIS
    a_warmup_once: assert property (@(posedge clk) disable iff (!rst_n)
        !$rose(warmup_reg))
        else $error("warm-up flag set again after clearing");
    a_ppm_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.ppm_valid) |->
            (!result_reg.warming_up && result_reg.status == cfp_pkg::STATUS_OK))
        else $error("ppm flagged valid on a rejected or warm-up result");
`endif

endmodule

// File: rtl/core/co2_sensor_frame_parser_top.sv
// CO2 sensor frame parser, top level: front end, event queue, back end.
// Depends on cfp_pkg, cfp_front, cfp_queue, cfp_back.
//
// Input channel (push/full): opcode 0 carries a received UART byte in
// rx_byte, opcode 1 marks one elapsed second. One transaction is taken per
// cycle whenever full is low.
// Result channel (empty/pop): one result per completed nine-byte frame,
// valid while empty is low, taken on pop. Rejected frames report status
// 1 (checksum) or 2 (not a reading reply) with zeroed reading fields.
// Config channel (cfg_valid/cfg_ready): index 0 warmup_seconds, index 1
// min_valid_ppm; cfg_ready is always high. Write only while idle.
// With the queue empty, a frame's event enters the queue as its checksum
// byte is taken; the back end loads the result register from the queue
// head unless an unpopped result holds it. Throughput is one input
// transaction per cycle while full is low. When pop stays low the result
// register holds, the back end stalls at the next frame event (ticks still
// drain) and the event queue (QUEUE_DEPTH entries) fills before full rises.
// Reset clears framing, uptime, queue and result valid flag, sets warm-up
// and loads the register defaults 180 and 250.
module co2_sensor_frame_parser_top #(
    parameter int QUEUE_DEPTH = cfp_pkg::QUEUE_DEPTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic                             opcode,
    input  logic [7:0]                       rx_byte,
    output logic                             empty,
    input  logic                             pop,
    output logic [1:0]                       frame_status,
    output logic [15:0]                      ppm,
    output logic [7:0]                       temperature,
    output logic [7:0]                       extra_byte,
    output logic                             warming_up,
    output logic                             ppm_valid,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [cfp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [cfp_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic             accept;
    logic             enq_valid;
    cfp_pkg::event_t  enq_event;
    logic             deq_valid;
    logic             deq_ready;
    cfp_pkg::event_t  deq_event;
    logic             out_valid;
    cfp_pkg::result_t result;

    assign accept    = push && !full;
    assign cfg_ready = 1'b1;
    assign empty     = !out_valid;

    assign frame_status = result.status;
    assign ppm          = result.ppm;
    assign temperature  = result.temperature;
    assign extra_byte   = result.extra_byte;
    assign warming_up   = result.warming_up;
    assign ppm_valid    = result.ppm_valid;

    cfp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .opcode    (opcode),
        .rx_byte   (rx_byte),
        .enq_valid (enq_valid),
        .enq_event (enq_event)
    );

    cfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .enq_valid (enq_valid),
        .enq_event (enq_event),
        .full      (full),
        .deq_valid (deq_valid),
        .deq_event (deq_event),
        .deq_ready (deq_ready)
    );

    cfp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .deq_valid (deq_valid),
        .deq_event (deq_event),
        .deq_ready (deq_ready),
        .out_valid (out_valid),
        .out_pop   (pop),
        .result    (result)
    );

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// Testbench for co2_sensor_frame_parser_top: directed and random UART frames
// and ticks, checked against a frame scoreboard class.
// Depends on cfp_pkg and co2_sensor_frame_parser_top.
module tb;

    localparam int CYCLE_LIMIT = 1_500_000;

    class frame_scoreboard;
        logic [15:0] warmup_limit;
        logic [15:0] ppm_floor;
        logic [3:0]  position;
        logic [7:0]  frame_buf [8];
        logic [7:0]  sum_acc;
        logic [15:0] uptime;
        bit          warming;
        cfp_pkg::result_t expected_q [$];
        int          errors;
        int          results_seen [3];

        function new();
            warmup_limit = cfp_pkg::WARMUP_SECONDS_RST;
            ppm_floor    = cfp_pkg::MIN_VALID_PPM_RST;
            position     = '0;
            sum_acc      = '0;
            uptime       = '0;
            warming      = 1'b1;
            errors       = 0;
            foreach (frame_buf[i])
                frame_buf[i] = '0;
            foreach (results_seen[i])
                results_seen[i] = 0;
        endfunction

        function void set_reg(cfp_pkg::cfg_index_t idx, logic [15:0] value);
            if (idx == cfp_pkg::CFG_WARMUP_SECONDS)
                warmup_limit = value;
            else
                ppm_floor = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Advance the parser state by one accepted input transaction
        function void take_item(cfp_pkg::opcode_t op, logic [7:0] b);
            cfp_pkg::result_t r;
            logic [7:0]  want_sum;
            logic [15:0] reading;
            if (op == cfp_pkg::OP_TICK)
            begin
                if (uptime != cfp_pkg::UPTIME_MAX)
                    uptime++;
                return;
            end
            if (position == 0)
            begin
                if (b == cfp_pkg::HEADER_BYTE)
                begin
                    position = 1;
                    sum_acc  = '0;
                end
                return;
            end
            frame_buf[position - 1] = b;
            if (position < cfp_pkg::FRAME_LENGTH - 1)
            begin
                sum_acc  = sum_acc + b;
                position = position + 1;
                return;
            end
            position = '0;
            r        = '0;
            want_sum = 8'd0 - sum_acc;
            if (b != want_sum)
            begin
                r.status     = cfp_pkg::STATUS_BAD_CHECKSUM;
                r.warming_up = warming;
            end
            else if (frame_buf[0] != cfp_pkg::READ_COMMAND)
            begin
                r.status     = cfp_pkg::STATUS_NOT_READING;
                r.warming_up = warming;
            end
            else
            begin
                reading = {frame_buf[1], frame_buf[2]};
                if (warming && (uptime > warmup_limit || frame_buf[5] != 8'd0))
                    warming = 1'b0;
                r.status      = cfp_pkg::STATUS_OK;
                r.ppm         = reading;
                r.temperature = frame_buf[3] - cfp_pkg::TEMP_OFFSET;
                r.extra_byte  = frame_buf[5];
                r.warming_up  = warming;
                r.ppm_valid   = !warming && reading >= ppm_floor;
            end
            expected_q.push_back(r);
        endfunction

        function void compare_field(string field, logic [15:0] want_v, logic [15:0] got_v);
            if (want_v !== got_v)
            begin
                $display("%0t: %s mismatch, expected %h, actual %h",
                         $time, field, want_v, got_v);
                errors++;
            end
        endfunction

        function void check_reading(cfp_pkg::result_t got);
            cfp_pkg::result_t want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result, status %0d ppm %h",
                         $time, got.status, got.ppm);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            results_seen[int'(want.status)]++;
            compare_field("frame_status", 16'(want.status), 16'(got.status));
            compare_field("ppm", want.ppm, got.ppm);
            compare_field("temperature", 16'(want.temperature), 16'(got.temperature));
            compare_field("extra_byte", 16'(want.extra_byte), 16'(got.extra_byte));
            compare_field("warming_up", 16'(want.warming_up), 16'(got.warming_up));
            compare_field("ppm_valid", 16'(want.ppm_valid), 16'(got.ppm_valid));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic        opcode = 1'b0;
    logic [7:0]  rx_byte = 8'h00;
    logic        empty;
    logic        pop = 1'b0;
    logic [1:0]  frame_status;
    logic [15:0] ppm;
    logic [7:0]  temperature;
    logic [7:0]  extra_byte;
    logic        warming_up;
    logic        ppm_valid;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [cfp_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [cfp_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    frame_scoreboard sb = new();
    cfp_pkg::result_t popped;
    int      cycle_count = 0;
    int      items_sent = 0;
    int      items_taken = 0;
    int      cfg_writes = 0;
    int      calm_left [2] = '{0, 0};
    int      pop_gap;
    bit      hold_gaps = 1'b0;

    co2_sensor_frame_parser_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .opcode       (opcode),
        .rx_byte      (rx_byte),
        .empty        (empty),
        .pop          (pop),
        .frame_status (frame_status),
        .ppm          (ppm),
        .temperature  (temperature),
        .extra_byte   (extra_byte),
        .warming_up   (warming_up),
        .ppm_valid    (ppm_valid),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("co2_sensor_frame_parser_top test failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && push && !full)
        begin
            sb.take_item(cfp_pkg::opcode_t'(opcode), rx_byte);
            items_taken++;
        end
        if (rst_n && pop && !empty)
        begin
            popped.status      = cfp_pkg::status_t'(frame_status);
            popped.ppm         = ppm;
            popped.temperature = temperature;
            popped.extra_byte  = extra_byte;
            popped.warming_up  = warming_up;
            popped.ppm_valid   = ppm_valid;
            sb.check_reading(popped);
        end
    end

    // Mostly short gaps, occasionally long ones, with runs of no gaps at all
    function automatic int pick_gap(int side);
        int r;
        if (calm_left[side] > 0)
        begin
            calm_left[side]--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm_left[side] = $urandom_range(20, 80);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    initial
    begin
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            pop <= 1'b1;
            do @(posedge clk); while (empty);
            pop_gap = pick_gap(1);
            if (pop_gap > 0)
            begin
                pop <= 1'b0;
                repeat (pop_gap) @(posedge clk);
            end
        end
    end

    task automatic push_item(logic op, logic [7:0] b);
        int gap;
        push    <= 1'b1;
        opcode  <= op;
        rx_byte <= b;
        do @(posedge clk); while (full);
        items_sent++;
        gap = hold_gaps ? 0 : pick_gap(0);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_reg(cfp_pkg::cfg_index_t idx, logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, value);
        cfg_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Wait until every expected result has been popped and the queue is quiet
    task automatic drain_parser();
        push <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    // Sends the first cut bytes of a frame; ticks may be slipped in before any byte
    task automatic send_frame(logic [7:0] cmd, logic [15:0] reading, logic [7:0] temp_raw,
                              logic [7:0] extra, bit sum_ok, int tick_pct, int cut);
        logic [7:0] fb [9];
        logic [7:0] acc;
        fb[0] = cfp_pkg::HEADER_BYTE;
        fb[1] = cmd;
        fb[2] = reading[15:8];
        fb[3] = reading[7:0];
        fb[4] = temp_raw;
        fb[5] = 8'($urandom);
        fb[6] = extra;
        fb[7] = 8'($urandom);
        acc = '0;
        for (int i = 1; i < 8; i++)
            acc = acc + fb[i];
        fb[8] = 8'd0 - acc;
        if (!sum_ok)
            fb[8] = fb[8] ^ 8'($urandom_range(1, 255));
        for (int i = 0; i < cut; i++)
        begin
            if ($urandom_range(0, 99) < tick_pct)
                push_item(cfp_pkg::OP_TICK, 8'($urandom));
            push_item(cfp_pkg::OP_BYTE, fb[i]);
        end
    endtask

    task automatic send_random_frame(int cut);
        logic [7:0]  cmd;
        logic [15:0] reading;
        logic [7:0]  extra;
        cmd = ($urandom_range(0, 99) < 85) ? cfp_pkg::READ_COMMAND : 8'($urandom);
        case ($urandom_range(0, 5))
            0: reading = sb.ppm_floor - 16'd1;
            1: reading = sb.ppm_floor;
            2: reading = sb.ppm_floor + 16'd1;
            3: reading = 16'hFFFF;
            4: reading = 16'h0000;
            default: reading = 16'($urandom);
        endcase
        extra = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
        send_frame(cmd, reading, 8'($urandom), extra, $urandom_range(0, 99) < 80,
                   $urandom_range(0, 1) ? 5 : 0, cut);
    endtask

    task automatic run_random(int quota);
        int first;
        int r;
        first = items_sent;
        while (items_sent - first < quota)
        begin
            r = $urandom_range(0, 99);
            if (r < 80)
                send_random_frame(cfp_pkg::FRAME_LENGTH);
            else if (r < 88)
                send_random_frame($urandom_range(1, cfp_pkg::FRAME_LENGTH - 1));
            else if (r < 95)
                repeat ($urandom_range(1, 3)) push_item(cfp_pkg::OP_BYTE, 8'($urandom));
            else
                repeat ($urandom_range(1, 4)) push_item(cfp_pkg::OP_TICK, 8'($urandom));
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: noise while hunting, a tick carrying 0xFF, warm-up held
        push_item(cfp_pkg::OP_BYTE, 8'h00);
        push_item(cfp_pkg::OP_BYTE, 8'h7F);
        push_item(cfp_pkg::OP_TICK, cfp_pkg::HEADER_BYTE);
        send_frame(cfp_pkg::READ_COMMAND, 16'hFFFF, 8'h00, 8'h00, 1'b1, 0,
                   cfp_pkg::FRAME_LENGTH);
        send_frame(cfp_pkg::READ_COMMAND, 16'hFF00, 8'h28, 8'h00, 1'b0, 50,
                   cfp_pkg::FRAME_LENGTH);
        send_frame(8'h79, 16'h0000, 8'hFF, 8'h80, 1'b1, 0, cfp_pkg::FRAME_LENGTH);

        // warm-up held while uptime equals the limit, released one tick later
        drain_parser();
        write_reg(cfp_pkg::CFG_WARMUP_SECONDS, sb.uptime + 16'd20);
        write_reg(cfp_pkg::CFG_MIN_VALID_PPM, 16'h0000);
        hold_gaps = 1'b1;
        repeat (20) push_item(cfp_pkg::OP_TICK, 8'($urandom));
        hold_gaps = 1'b0;
        send_frame(cfp_pkg::READ_COMMAND, 16'h0000, 8'd65, 8'h00, 1'b1, 0,
                   cfp_pkg::FRAME_LENGTH);
        push_item(cfp_pkg::OP_TICK, 8'($urandom));
        send_frame(cfp_pkg::READ_COMMAND, 16'h0000, 8'd65, 8'h00, 1'b1, 0,
                   cfp_pkg::FRAME_LENGTH);

        for (int phase = 0; phase < 4; phase++)
        begin
            drain_parser();
            case (phase)
                0:
                begin
                    write_reg(cfp_pkg::CFG_WARMUP_SECONDS, 16'h0000);
                    write_reg(cfp_pkg::CFG_MIN_VALID_PPM, 16'hFFFF);
                end
                1:
                begin
                    write_reg(cfp_pkg::CFG_WARMUP_SECONDS, 16'($urandom));
                    write_reg(cfp_pkg::CFG_MIN_VALID_PPM, 16'($urandom));
                end
                2:
                begin
                    write_reg(cfp_pkg::CFG_WARMUP_SECONDS, cfp_pkg::WARMUP_SECONDS_RST);
                    write_reg(cfp_pkg::CFG_MIN_VALID_PPM, cfp_pkg::MIN_VALID_PPM_RST);
                end
                default:
                begin
                    write_reg(cfp_pkg::CFG_WARMUP_SECONDS, 16'($urandom));
                    write_reg(cfp_pkg::CFG_MIN_VALID_PPM, 16'($urandom_range(0, 2000)));
                end
            endcase
            run_random(250);
        end

        drain_parser();
        $display("Accepted %0d input transactions and %0d register writes.",
                 items_taken, cfg_writes);
        $display("Frames checked: %0d readings, %0d checksum rejects, %0d non-reading rejects.",
                 sb.results_seen[0], sb.results_seen[1], sb.results_seen[2]);
        if (sb.errors == 0)
            $display("co2_sensor_frame_parser_top test passed");
        else
            $display("co2_sensor_frame_parser_top test failed");
        $finish;
    end
endmodule
